// ----- design/rau_pkg.sv -----
`default_nettype none
package rau_pkg;

    localparam int IN_BITS = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [IN_BITS-1:0] a_num;
        logic signed [IN_BITS-1:0] a_den;
        logic signed [IN_BITS-1:0] b_num;
        logic signed [IN_BITS-1:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [IN_BITS-1:0] res_num;
        logic [IN_BITS-2:0]        res_den;
        logic                      is_undefined;
        logic                      overflow;
    } t_res;

endpackage
`default_nettype wire

// ----- design/rau_if.sv -----
`default_nettype none
interface rau_req_if;
    logic          valid;
    logic          ready;
    rau_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_res_if;
    logic          valid;
    logic          ready;
    rau_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/rau_div.sv -----
`default_nettype none
module rau_div #(
    parameter int DW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_dv;
    logic [DW:0]   sh;
    logic          fit;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        sh  = {r_rem, r_quo[DW-1]};
        fit = sh >= {1'b0, r_dv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dv  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fit ? DW'(sh - {1'b0, r_dv}) : sh[DW-1:0];
            r_quo <= {r_quo[DW-2:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

// ----- design/rational_arithmetic_unit.sv -----
`default_nettype none
// Channel   Direction  Payload
// i_req     in         req_type, a_num, a_den, b_num, b_den
// o_res     out        res_num, res_den, is_undefined, overflow
//
// One transaction at a time: i_req.ready is high only while the unit is idle.
// A normal item forms three products on the shared multiplier, combines them, runs the
// binary GCD loop, then divides numerator and denominator by the GCD's odd part on the
// bit-serial divider. Undefined results are offered in the cycle after acceptance, zero
// results after the multiply and combine states. The result holds on o_res until taken;
// reset is synchronous, active low.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rau_req_if.sink     i_req,
    rau_res_if.source   o_res
);
    localparam int W = WORD_BITS;
    localparam int P = 2 * W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_ADD  = 7'b0000100,
        ST_GCD  = 7'b0001000,
        ST_DIVN = 7'b0010000,
        ST_DIVD = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state        r_state;
    logic [1:0]    r_step;
    logic [1:0]    r_op;
    logic [W-1:0]  r_anm, r_adm, r_bnm, r_bdm;
    logic          r_an, r_ad, r_bn, r_bd;
    logic [P-1:0]  r_nm, r_q, r_dm, r_x, r_y;
    logic          r_neg;
    logic          r_div_start;
    rau_pkg::t_res r_res;

    logic [W-1:0]  anm, adm, bnm, bdm;
    logic          an, ad, bn, bd, undef;
    logic [W-1:0]  mul_a, mul_b;
    logic [P-1:0]  prod;
    logic          ps, qs;
    logic [P-1:0]  sum_nm;
    logic          sum_neg;
    logic          div_done;
    logic [P-1:0]  div_quot;
    logic [P-1:0]  lim;
    logic          ovf;
    logic signed [W-1:0] snum;

    always_comb begin
        an  = i_req.data.a_num[W-1];
        ad  = i_req.data.a_den[W-1];
        bn  = i_req.data.b_num[W-1];
        bd  = i_req.data.b_den[W-1];
        anm = an ? W'(~i_req.data.a_num[W-1:0] + 1'b1) : i_req.data.a_num[W-1:0];
        adm = ad ? W'(~i_req.data.a_den[W-1:0] + 1'b1) : i_req.data.a_den[W-1:0];
        bnm = bn ? W'(~i_req.data.b_num[W-1:0] + 1'b1) : i_req.data.b_num[W-1:0];
        bdm = bd ? W'(~i_req.data.b_den[W-1:0] + 1'b1) : i_req.data.b_den[W-1:0];
        undef = (adm == '0) || (bdm == '0) ||
                ((i_req.data.req_type == rau_pkg::OP_DIV) && (bnm == '0));
    end

    // Shared multiplier: numerator or first cross product, second cross product, denominator product.
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = r_anm;
                mul_b = (r_op == rau_pkg::OP_MUL) ? r_bnm : r_bdm;
            end
            2'd1: begin
                mul_a = r_bnm;
                mul_b = r_adm;
            end
            default: begin
                mul_a = r_adm;
                mul_b = (r_op == rau_pkg::OP_DIV) ? r_bnm : r_bdm;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        ps = r_an ^ r_bd;
        qs = r_bn ^ r_ad ^ (r_op == rau_pkg::OP_SUB);
        if (r_op == rau_pkg::OP_MUL || r_op == rau_pkg::OP_DIV) begin
            sum_nm  = r_nm;
            sum_neg = r_an ^ r_ad ^ r_bn ^ r_bd;
        end else if (ps == qs) begin
            sum_nm  = r_nm + r_q;
            sum_neg = ps;
        end else if (r_nm >= r_q) begin
            sum_nm  = r_nm - r_q;
            sum_neg = ps;
        end else begin
            sum_nm  = r_q - r_nm;
            sum_neg = qs;
        end
    end

    rau_div #(.DW(P)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend ((r_state == ST_DIVN) ? r_nm : r_dm),
        .i_divisor  (r_x),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Final check uses the reduced numerator and the denominator quotient.
    always_comb begin
        lim  = P'(1) << (W - 1);
        ovf  = (div_quot > lim - 1'b1) ||
               (r_neg ? (r_nm > lim) : (r_nm > lim - 1'b1));
        snum = r_neg ? W'(~r_nm[W-1:0] + 1'b1) : r_nm[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_step      <= '0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_step  <= '0;
                        r_state <= undef ? ST_OUT : ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd2) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_state <= (sum_nm == '0) ? ST_OUT : ST_GCD;
                end
                ST_GCD: begin
                    if (r_x[0] && r_y[0] && r_x == r_y) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIVN;
                    end
                end
                ST_DIVN: begin
                    if (div_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIVD;
                    end
                end
                ST_DIVD: begin
                    if (div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (o_res.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_op  <= i_req.data.req_type;
                r_anm <= anm;
                r_adm <= adm;
                r_bnm <= bnm;
                r_bdm <= bdm;
                r_an  <= an;
                r_ad  <= ad;
                r_bn  <= bn;
                r_bd  <= bd;
                r_res <= '{res_num: '0, res_den: '0, is_undefined: 1'b1, overflow: 1'b0};
            end
            ST_MUL: begin
                if (r_step == 2'd0) begin
                    r_nm <= prod;
                end else if (r_step == 2'd1) begin
                    r_q <= prod;
                end else begin
                    r_dm <= prod;
                end
            end
            ST_ADD: begin
                r_nm  <= sum_nm;
                r_neg <= sum_neg;
                r_x   <= sum_nm;
                r_y   <= r_dm;
                r_res <= '{res_num: '0, res_den: (rau_pkg::IN_BITS-1)'(1),
                           is_undefined: 1'b0, overflow: 1'b0};
            end
            ST_GCD: begin
                // Common factors of two leave numerator and denominator at once;
                // afterwards one operand stays odd and the divisor is the odd part.
                if (!r_x[0] && !r_y[0]) begin
                    r_x  <= r_x >> 1;
                    r_y  <= r_y >> 1;
                    r_nm <= r_nm >> 1;
                    r_dm <= r_dm >> 1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else if (r_y > r_x) begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    r_nm <= div_quot;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    if (ovf) begin
                        r_res <= '{res_num: '0, res_den: '0,
                                   is_undefined: 1'b0, overflow: 1'b1};
                    end else begin
                        r_res <= '{res_num: rau_pkg::IN_BITS'(snum),
                                   res_den: (rau_pkg::IN_BITS-1)'(div_quot[W-2:0]),
                                   is_undefined: 1'b0, overflow: 1'b0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = (r_state == ST_OUT);
    assign o_res.data  = r_res;
endmodule
`default_nettype wire

// ----- tb/sv/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_tb;

    localparam int N_RANDOM = 1330;

    typedef struct {
        rau_pkg::t_op  op;
        logic [31:0]   an, ad, bn, bd;
        bit            has_fixed;
        rau_pkg::t_res fixed;
    } t_vec;

    logic i_clk;
    logic i_rst_n;
    rau_req_if req_ch ();
    rau_res_if res_ch ();

    rational_arithmetic_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    rau_pkg::t_res expected_q[$];
    int   n_errors = 0;
    bit   stim_done = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [63:0] split_mag(input logic [31:0] v, output bit neg);
        logic [31:0] m;
        neg = v[31];
        m = neg ? (~v + 32'd1) : v;
        return {32'd0, m};
    endfunction

    // Exact rational result, reduced, with sign carried on the numerator.
    function automatic rau_pkg::t_res rational_result(input rau_pkg::t_op op,
                                                      input logic [31:0] an,
                                                      input logic [31:0] ad,
                                                      input logic [31:0] bn,
                                                      input logic [31:0] bd);
        rau_pkg::t_res r;
        bit sa_n, sa_d, sb_n, sb_d, ps, qs, neg;
        logic [63:0] am, adm, bm, bdm, p, q, nm, dm, x, y, t;
        r = '0;
        am = split_mag(an, sa_n);
        adm = split_mag(ad, sa_d);
        bm = split_mag(bn, sb_n);
        bdm = split_mag(bd, sb_d);
        if (adm == 0 || bdm == 0 || (op == rau_pkg::OP_DIV && bm == 0)) begin
            r.is_undefined = 1'b1;
            return r;
        end
        case (op) inside
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                p = am * bdm;
                q = bm * adm;
                ps = sa_n != sb_d;
                qs = (sb_n != sa_d) != (op == rau_pkg::OP_SUB);
                if (ps == qs) begin
                    nm = p + q; neg = ps;
                end else if (p >= q) begin
                    nm = p - q; neg = ps;
                end else begin
                    nm = q - p; neg = qs;
                end
                dm = adm * bdm;
            end
            rau_pkg::OP_MUL: begin
                nm = am * bm; dm = adm * bdm;
                neg = (sa_n != sb_n) != (sa_d != sb_d);
            end
            default: begin
                nm = am * bdm; dm = adm * bm;
                neg = (sa_n != sb_d) != (sa_d != sb_n);
            end
        endcase
        if (nm == 0) begin
            r.res_den = 31'd1;
            return r;
        end
        x = nm; y = dm;
        while (y != 0) begin
            t = x % y; x = y; y = t;
        end
        nm = nm / x; dm = dm / x;
        if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
            r.overflow = 1'b1;
            return r;
        end
        r.res_num = neg ? 32'(-nm) : 32'(nm);
        r.res_den = dm[30:0];
        return r;
    endfunction

    function automatic t_vec mk(input rau_pkg::t_op op, input logic [31:0] an,
                                input logic [31:0] ad, input logic [31:0] bn,
                                input logic [31:0] bd);
        t_vec v;
        v.op = op; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
        v.has_fixed = 0; v.fixed = '0;
        return v;
    endfunction

    function automatic t_vec mkf(input rau_pkg::t_op op, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [31:0] bd,
                                 input logic [31:0] rn, input logic [30:0] rd,
                                 input bit undef, input bit ovf);
        t_vec v;
        v = mk(op, an, ad, bn, bd);
        v.has_fixed = 1;
        v.fixed.res_num = rn; v.fixed.res_den = rd;
        v.fixed.is_undefined = undef; v.fixed.overflow = ovf;
        return v;
    endfunction

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] M1   = 32'hFFFF_FFFF;

    t_vec directed[$];

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 20)) - 10);
            1: return MAXP;
            2: return MINN;
            3: return 32'($urandom_range(0, 65535)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input t_vec v);
        rau_pkg::t_res e;
        // The unit is never ready in the cycle after an acceptance, so the extra
        // edge costs no throughput and keeps valid from being driven twice at once.
        repeat (gap_len() + 1) @(posedge i_clk);
        e = rational_result(v.op, v.an, v.ad, v.bn, v.bd);
        if (v.has_fixed && e !== v.fixed) begin
            $error("table row disagrees with prediction: %h vs %h", v.fixed, e);
            n_errors++;
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= '{req_type: v.op, a_num: v.an, a_den: v.ad, b_num: v.bn, b_den: v.bd};
        do @(posedge i_clk); while (!req_ch.ready);
        expected_q.push_back(v.has_fixed ? v.fixed : e);
        req_ch.valid <= 1'b0;
    endtask

    initial begin
        t_vec v;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        directed.push_back(mkf(rau_pkg::OP_ADD, 1, 0, 1, 1, 0, 0, 1, 0));
        directed.push_back(mkf(rau_pkg::OP_SUB, 1, 1, 1, 0, 0, 0, 1, 0));
        directed.push_back(mkf(rau_pkg::OP_DIV, 3, 4, 0, 5, 0, 0, 1, 0));
        directed.push_back(mkf(rau_pkg::OP_MUL, 0, 7, 5, 3, 0, 1, 0, 0));
        directed.push_back(mkf(rau_pkg::OP_ADD, 1, 2, 1, 3, 5, 6, 0, 0));
        directed.push_back(mkf(rau_pkg::OP_SUB, 1, 2, 1, 3, 1, 6, 0, 0));
        directed.push_back(mkf(rau_pkg::OP_MUL, 2, 3, 3, 4, 1, 2, 0, 0));
        directed.push_back(mkf(rau_pkg::OP_DIV, 1, 2, 1, 4, 2, 1, 0, 0));
        // The sum takes no sign from the product of the denominators.
        directed.push_back(mkf(rau_pkg::OP_ADD, 1, M1, 0, 1, 1, 1, 0, 0));
        directed.push_back(mkf(rau_pkg::OP_SUB, 5, 5, 5, 5, 0, 1, 0, 0));
        directed.push_back(mkf(rau_pkg::OP_MUL, MINN, 1, 1, 1, MINN, 1, 0, 0));
        directed.push_back(mkf(rau_pkg::OP_MUL, MINN, 1, M1, 1, 0, 0, 0, 1));
        directed.push_back(mkf(rau_pkg::OP_DIV, 1, MINN, 1, 1, 0, 0, 0, 1));
        directed.push_back(mkf(rau_pkg::OP_ADD, MAXP, 1, MAXP, 1, 0, 0, 0, 1));
        directed.push_back(mkf(rau_pkg::OP_MUL, MAXP, 1, 1, MAXP, 1, 1, 0, 0));
        directed.push_back(mk(rau_pkg::OP_ADD, MINN, MINN, MINN, MINN));
        directed.push_back(mk(rau_pkg::OP_SUB, MINN, MAXP, MAXP, MINN));
        directed.push_back(mk(rau_pkg::OP_MUL, M1, M1, M1, M1));
        directed.push_back(mk(rau_pkg::OP_DIV, MINN, MAXP, MINN, MAXP));
        directed.push_back(mk(rau_pkg::OP_ADD, 1, MAXP, 1, MAXP - 1));
        directed.push_back(mk(rau_pkg::OP_DIV, MAXP, MINN, M1, MAXP));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2)
                while (expected_q.size() != 0) @(posedge i_clk);
            v = mk(rau_pkg::t_op'($urandom_range(0, 3)), rand_word(), rand_word(),
                   rand_word(), rand_word());
            // Keep undefined inputs to a small share of the random traffic.
            if (v.ad == 0 && $urandom_range(0, 3) != 0) v.ad = 32'd1;
            if (v.bd == 0 && $urandom_range(0, 3) != 0) v.bd = 32'd3;
            send(v);
        end
        stim_done = 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge i_clk) begin
        rau_pkg::t_res e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", res_ch.data);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (res_ch.data.res_num !== e.res_num) begin
                    $error("res_num expected %0d actual %0d", e.res_num, res_ch.data.res_num);
                    n_errors++;
                end
                if (res_ch.data.res_den !== e.res_den) begin
                    $error("res_den expected %0d actual %0d", e.res_den, res_ch.data.res_den);
                    n_errors++;
                end
                if (res_ch.data.is_undefined !== e.is_undefined) begin
                    $error("is_undefined expected %0b actual %0b", e.is_undefined,
                           res_ch.data.is_undefined);
                    n_errors++;
                end
                if (res_ch.data.overflow !== e.overflow) begin
                    $error("overflow expected %0b actual %0b", e.overflow,
                           res_ch.data.overflow);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("rational_arithmetic_unit verification clean");
        else
            $display("rational_arithmetic_unit verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("rational_arithmetic_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
design/rau_pkg.sv
design/rau_if.sv
design/rau_div.sv
design/rational_arithmetic_unit.sv
tb/sv/rational_arithmetic_unit_tb.sv
